// ===== hw/rtl/arena_bump_and_slab_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARENA_BUMP_AND_SLAB_ALLOCATOR_UNIT_ASSERT_SVH
`define ARENA_BUMP_AND_SLAB_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define ABSA_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ABSA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/absa_pkg.sv =====
// ----------------------------------------------------------------------------
// Allocator package
// Word types, operation, status, policy and register codes, fixed widths.
// ----------------------------------------------------------------------------
package absa_pkg;

	localparam int GRANULE    = 32;
	localparam int GRAN_SHIFT = 5;
	localparam int ROUND_MASK = 7;
	localparam int SIZE_W     = 18;
	localparam int OFS_W      = 17;
	localparam int ADDR_W     = 32;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [1:0] POL_BUMP = 2'd0;
	localparam logic [1:0] POL_SLAB = 2'd1;

	localparam logic [1:0] REG_POLICY   = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_BASE     = 2'd2;

	localparam logic [OFS_W-1:0] CAPACITY_RESET = 17'h10000;

	typedef struct packed {
		logic [1:0]        op;
		logic [OFS_W-1:0]  req_size;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted_address;
		logic [OFS_W-1:0]  used_bytes;
	} rsp_t;

	typedef struct packed {
		logic [1:0]        index;
		logic [ADDR_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic we;
		logic clear;
		logic wr_valid;
	} head_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_POP   = 5'b00100,
		S_CARVE = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

endpackage

// ===== hw/rtl/absa_chan_if.sv =====
// ----------------------------------------------------------------------------
// Allocator channel
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
interface absa_chan_if #(parameter type T = logic) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== hw/rtl/absa_link_ram.sv =====
// ----------------------------------------------------------------------------
// Slot link memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module absa_link_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/absa_head_table.sv =====
// ----------------------------------------------------------------------------
// Class head table
// Free list head and valid flag per size class; only the valid flags are cleared on reset.
// ----------------------------------------------------------------------------
module absa_head_table import absa_pkg::*; #(
	parameter int CLASS_COUNT = 8,
	parameter int KW          = 3,
	parameter int GW          = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [KW-1:0] cls,
	input  head_ctl_t     ctl,
	input  logic [GW-1:0] wr_gran,
	output logic [GW-1:0] rd_gran,
	output logic          rd_valid
);

	logic [GW-1:0]          head_q  [CLASS_COUNT];
	logic [CLASS_COUNT-1:0] valid_q;

	assign rd_gran  = head_q[cls];
	assign rd_valid = valid_q[cls];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.we) begin
			valid_q[cls] <= ctl.wr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			head_q[cls] <= wr_gran;
		end
	end

endmodule

// ===== hw/rtl/arena_bump_and_slab_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Arena bump and slab allocator: bump, free, reset and failures pass through EXEC
// and FIN, a slab pop through EXEC, POP (link read) and FIN, a carve through EXEC,
// CARVE (one link write per slot after slot 0) and FIN; one request at a time; result waits in a reg.
// Reset clears config, bump offset and class heads at once; link RAM is not.
// ----------------------------------------------------------------------------
`include "arena_bump_and_slab_allocator_unit_assert.svh"

module arena_bump_and_slab_allocator_unit import absa_pkg::*; #(
	parameter int ARENA_BYTES = 65536,
	parameter int CLASS_COUNT = 8,
	parameter int CARVE_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	absa_chan_if.sink   cfg,
	absa_chan_if.sink   req,
	absa_chan_if.source rsp
);

	localparam int LINK_DEPTH = ARENA_BYTES / GRANULE;
	localparam int GW  = $clog2(LINK_DEPTH);
	localparam int LW  = GW + 1;
	localparam int KW  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int CSW = $clog2(CARVE_SLOTS);
	localparam int CHW = $clog2(CARVE_SLOTS + 1) + GRAN_SHIFT + CLASS_COUNT - 1;
	localparam int OW0 = (CHW > OFS_W) ? CHW : OFS_W;
	localparam int OW  = (OW0 > GW + GRAN_SHIFT) ? OW0 : GW + GRAN_SHIFT;

	state_t            state_q, nxt_state;
	logic [1:0]        policy_q;
	logic [OFS_W-1:0]  cap_q;
	logic [ADDR_W-1:0] base_q;
	logic [OFS_W-1:0]  bump_q, bump_d;
	logic [OFS_W-1:0]  start_q, start_d;
	logic [CSW-1:0]    idx_q, idx_d;
	logic [1:0]        st_q, st_d;
	logic [ADDR_W-1:0] grant_q, grant_d;
	req_t              req_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic              in_ready, out_free;

	logic [SIZE_W-1:0] rsize;
	logic [KW-1:0]     cls;
	logic              cls_none;
	logic [OFS_W-1:0]  cap, room;
	logic              base_ok, bump_fit, carve_fit, free_ok;
	logic [OW-1:0]     chunk, slot_off;
	logic [ADDR_W-1:0] foff;
	logic [GW-1:0]     fgran, cgran;

	logic [GW-1:0]     hd_gran, h_wgran;
	logic              hd_valid;
	head_ctl_t         hctl;

	logic              lk_we, lk_re;
	logic [GW-1:0]     lk_waddr;
	logic [LW-1:0]     lk_wdata, lk_rdata;

	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// size decode
	assign rsize = ({1'b0, req_q.req_size} + SIZE_W'(ROUND_MASK)) & ~SIZE_W'(ROUND_MASK);

	always_comb begin
		cls      = '0;
		cls_none = 1'b1;
		for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
			if (rsize <= (SIZE_W'(GRANULE) << k)) begin
				cls      = KW'(k);
				cls_none = 1'b0;
			end
		end
	end

	assign cap       = (32'(cap_q) < 32'(ARENA_BYTES)) ? cap_q : OFS_W'(ARENA_BYTES);
	assign base_ok   = bump_q <= cap;
	assign room      = cap - bump_q;
	assign bump_fit  = base_ok && (rsize <= SIZE_W'(room));
	assign chunk     = (OW'(CARVE_SLOTS) << GRAN_SHIFT) << cls;
	assign carve_fit = base_ok && (chunk <= OW'(room));

	assign foff    = req_q.free_address - base_q;
	assign free_ok = !cls_none && (foff < 32'(ARENA_BYTES)) && (foff[GRAN_SHIFT-1:0] == '0);
	assign fgran   = foff[GW+GRAN_SHIFT-1:GRAN_SHIFT];

	assign slot_off = OW'(start_q) + ((OW'(idx_q) << GRAN_SHIFT) << cls);
	assign cgran    = slot_off[GW+GRAN_SHIFT-1:GRAN_SHIFT];

	always_comb begin
		nxt_state = state_q;
		in_ready  = 1'b0;
		hctl      = '0;
		h_wgran   = fgran;
		lk_we     = 1'b0;
		lk_waddr  = fgran;
		lk_wdata  = {hd_valid, hd_gran};
		lk_re     = 1'b0;
		bump_d    = bump_q;
		start_d   = start_q;
		idx_d     = idx_q;
		st_d      = st_q;
		grant_d   = grant_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					nxt_state = S_EXEC;
				end
			end
			S_EXEC: begin
				nxt_state = S_FIN;
				st_d      = ST_IGNORED;
				grant_d   = '0;
				case (req_q.op)
					OP_ALLOC: begin
						st_d = ST_FAIL;
						if (policy_q == POL_SLAB) begin
							if (cls_none) begin
								st_d = ST_FAIL;
							end else if (hd_valid) begin
								lk_re     = 1'b1;
								st_d      = ST_OK;
								grant_d   = base_q + ADDR_W'({hd_gran, {GRAN_SHIFT{1'b0}}});
								nxt_state = S_POP;
							end else if (carve_fit) begin
								st_d      = ST_OK;
								grant_d   = base_q + ADDR_W'(bump_q);
								start_d   = bump_q;
								bump_d    = bump_q + OFS_W'(chunk);
								idx_d     = CSW'(1);
								nxt_state = S_CARVE;
							end
						end else if (bump_fit) begin
							st_d    = ST_OK;
							grant_d = base_q + ADDR_W'(bump_q);
							bump_d  = bump_q + OFS_W'(rsize);
						end
					end
					OP_FREE: begin
						if (policy_q == POL_SLAB) begin
							st_d = ST_FAIL;
							if (free_ok) begin
								st_d          = ST_OK;
								lk_we         = 1'b1;
								hctl.we       = 1'b1;
								hctl.wr_valid = 1'b1;
							end
						end
					end
					OP_RESET: begin
						if (policy_q inside {POL_BUMP, POL_SLAB}) begin
							st_d       = ST_OK;
							bump_d     = '0;
							hctl.clear = (policy_q == POL_SLAB);
						end
					end
					default: begin
						st_d = ST_IGNORED;
					end
				endcase
			end
			S_POP: begin
				hctl.we       = 1'b1;
				hctl.wr_valid = lk_rdata[GW];
				h_wgran       = lk_rdata[GW-1:0];
				nxt_state     = S_FIN;
			end
			S_CARVE: begin
				lk_we         = 1'b1;
				lk_waddr      = cgran;
				hctl.we       = 1'b1;
				hctl.wr_valid = 1'b1;
				h_wgran       = cgran;
				idx_d         = idx_q + CSW'(1);
				if (idx_q == CSW'(CARVE_SLOTS - 1)) begin
					nxt_state = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					in_ready  = 1'b1;
					nxt_state = req.valid ? S_EXEC : S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= POL_BUMP;
			cap_q       <= CAPACITY_RESET;
			base_q      <= '0;
			bump_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			bump_q  <= bump_d;
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_POLICY:   policy_q <= cfg.data.value[1:0];
					REG_CAPACITY: cap_q    <= cfg.data.value[OFS_W-1:0];
					REG_BASE:     base_q   <= cfg.data.value;
					default: begin
					end
				endcase
			end
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		idx_q   <= idx_d;
		st_q    <= st_d;
		grant_q <= grant_d;
		if (req.valid && in_ready) begin
			req_q <= req.data;
		end
		if (state_q == S_FIN && out_free) begin
			rsp_q <= '{status: st_q, granted_address: grant_q, used_bytes: bump_q};
		end
	end

	absa_head_table #(
		.CLASS_COUNT(CLASS_COUNT),
		.KW         (KW),
		.GW         (GW)
	) u_heads (
		.clk     (clk),
		.arst_n  (arst_n),
		.cls     (cls),
		.ctl     (hctl),
		.wr_gran (h_wgran),
		.rd_gran (hd_gran),
		.rd_valid(hd_valid)
	);

	absa_link_ram #(
		.DEPTH(LINK_DEPTH),
		.AW   (GW),
		.DW   (LW)
	) u_links (
		.clk  (clk),
		.we   (lk_we),
		.waddr(lk_waddr),
		.wdata(lk_wdata),
		.re   (lk_re),
		.raddr(hd_gran),
		.rdata(lk_rdata)
	);

	`ABSA_ASSERT_IMP(a_carve_idx_range, state_q == S_CARVE, idx_q != '0, "carve index wrapped")
	`ABSA_ASSERT_NEXT(a_carve_head_set, state_q == S_CARVE, hd_valid, "class head empty after carve push")
	`ABSA_ASSERT_IMP(a_fail_zero_grant, rsp_valid_q && (rsp_q.status != ST_OK), rsp_q.granted_address == '0, "nonzero address on failed word")
	`ABSA_ASSERT_IMP(a_load_from_fin, $rose(rsp_valid_q), $past(state_q == S_FIN), "result word loaded outside finish")

endmodule

// ===== tb/arena_bump_and_slab_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arena allocator unit test
// Sends allocate, free and reset words under several policy, capacity and
// base settings, predicts every result with a local copy of the bump pointer
// and the slab free lists, and checks each result word field by field.
// ----------------------------------------------------------------------------
module arena_bump_and_slab_allocator_unit_test import absa_pkg::*; ();

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam logic [1:0] POL_PERSIST = 2'd2;
	localparam logic [1:0] POL_SPARE   = 2'd3;
	localparam int ARENA       = 65536;
	localparam int CLASSES     = 8;
	localparam int CARVE       = 64;
	localparam int LINKS       = ARENA / GRANULE;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	absa_chan_if #(.T(cfg_t)) cfg ();
	absa_chan_if #(.T(req_t)) req ();
	absa_chan_if #(.T(rsp_t)) rsp ();

	arena_bump_and_slab_allocator_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	// local allocator state
	logic [1:0]        m_policy = POL_BUMP;
	logic [OFS_W-1:0]  m_capacity = CAPACITY_RESET;
	logic [ADDR_W-1:0] m_base = '0;
	int unsigned bump_ofs = 0;
	int unsigned used_cnt = 0;
	int unsigned head_gran [CLASSES];
	bit          head_live [CLASSES];
	int unsigned link_gran [LINKS];
	bit          link_live [LINKS];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];

	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned req_gap = 0;
	int unsigned req_calm = 0;
	int unsigned rsp_hold = 0;
	int unsigned rsp_calm = 0;
	bit          req_taken = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned stall_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned size_class(int unsigned sz);
		int unsigned k;
		k = 0;
		while (k < CLASSES && sz > (GRANULE << k))
			k++;
		return k;
	endfunction

	function automatic void push_slot(int unsigned k, int unsigned gran);
		if (gran < LINKS) begin
			link_gran[gran] = head_gran[k];
			link_live[gran] = head_live[k];
			head_gran[k] = gran;
			head_live[k] = 1'b1;
		end
	endfunction

	function automatic rsp_t alloc_result(req_t r);
		rsp_t o;
		int unsigned sz, room, k, g, cs, chunk, start;
		logic [ADDR_W-1:0] ofs;
		o.status = ST_IGNORED;
		o.granted_address = '0;
		sz = (32'(r.req_size) + ROUND_MASK) & 32'hFFFF_FFF8;
		room = (m_capacity < ARENA) ? m_capacity : ARENA;
		case (r.op)
			OP_ALLOC: begin
				o.status = ST_FAIL;
				if (m_policy == POL_SLAB) begin
					k = size_class(sz);
					if (k < CLASSES) begin
						if (head_live[k]) begin
							g = head_gran[k];
							if (g < LINKS) begin
								head_gran[k] = link_gran[g];
								head_live[k] = link_live[g];
							end else begin
								head_live[k] = 1'b0;
							end
							o.granted_address = m_base + g * GRANULE;
							o.status = ST_OK;
						end else begin
							cs = GRANULE << k;
							chunk = cs * CARVE;
							if (bump_ofs <= room && chunk <= room - bump_ofs) begin
								start = bump_ofs;
								bump_ofs += chunk;
								used_cnt += chunk;
								// slot 0 goes out, the rest stack up with the highest on top
								for (int unsigned i = 1; i < CARVE; i++)
									push_slot(k, (start + i * cs) / GRANULE);
								o.granted_address = m_base + start;
								o.status = ST_OK;
							end
						end
					end
				end else if (bump_ofs <= room && sz <= room - bump_ofs) begin
					o.granted_address = m_base + bump_ofs;
					bump_ofs += sz;
					used_cnt += sz;
					o.status = ST_OK;
				end
			end
			OP_FREE: begin
				if (m_policy == POL_SLAB) begin
					k = size_class(sz);
					ofs = r.free_address - m_base;
					o.status = ST_FAIL;
					if (k < CLASSES && ofs < ARENA && ofs[GRAN_SHIFT-1:0] == 0) begin
						push_slot(k, ofs / GRANULE);
						o.status = ST_OK;
					end
				end
			end
			OP_RESET: begin
				if (m_policy == POL_BUMP || m_policy == POL_SLAB) begin
					if (m_policy == POL_SLAB) begin
						for (int i = 0; i < CLASSES; i++) begin
							head_live[i] = 1'b0;
							head_gran[i] = 0;
						end
					end
					bump_ofs = 0;
					used_cnt = 0;
					o.status = ST_OK;
				end
			end
			default: ;
		endcase
		o.used_bytes = OFS_W'(used_cnt);
		return o;
	endfunction

	task automatic report(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		errors++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= cfg_t'{index: idx, value: value};
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			REG_POLICY:   m_policy = value[1:0];
			REG_CAPACITY: m_capacity = value[OFS_W-1:0];
			REG_BASE:     m_base = value;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_mode(logic [1:0] pol, int unsigned cap, logic [ADDR_W-1:0] base);
		write_reg(REG_POLICY, ADDR_W'(pol));
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_BASE, base);
	endtask

	task automatic settle();
		while (pending_reqs.size() != 0 || n_taken != n_queued || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	function automatic void queue_item(logic [1:0] op, int unsigned sz, logic [ADDR_W-1:0] addr);
		pending_reqs.push_back(req_t'{op: op, req_size: OFS_W'(sz), free_address: addr});
		n_queued++;
	endfunction

	function automatic void queue_random(logic [1:0] pol);
		int unsigned r, sz;
		logic [1:0] op;
		logic [ADDR_W-1:0] addr;
		r = $urandom_range(0, 99);
		if (r < 3)
			op = OP_RESET;
		else if (r < 4)
			op = OP_SPARE;
		else if (pol == POL_SLAB && r < 40)
			op = OP_FREE;
		else if (pol != POL_SLAB && r < 7)
			op = OP_FREE;
		else
			op = OP_ALLOC;
		r = $urandom_range(0, 99);
		if (r < 80)
			sz = $urandom_range(0, 600);
		else if (r < 95)
			sz = $urandom_range(0, 4096);
		else
			sz = $urandom_range(0, 131071);
		addr = $urandom();
		if (op == OP_FREE && $urandom_range(0, 99) < 85)
			addr = m_base + $urandom_range(0, LINKS - 1) * GRANULE;
		queue_item(op, sz, addr);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req.valid || req_taken)) begin
			req_taken = 1'b0;
			if (req_gap > 0) begin
				req_gap--;
				req.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req.data <= pending_reqs.pop_front();
				req.valid <= 1'b1;
				if (req_calm > 0) begin
					req_calm--;
					req_gap = 0;
				end else begin
					req_gap = stall_len();
					if ($urandom_range(0, 49) == 0)
						req_calm = $urandom_range(20, 80);
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// predict on every accepted request word
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			expected_rsps.push_back(alloc_result(req.data));
			n_taken++;
			req_taken = 1'b1;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp_calm > 0)
					rsp_calm--;
				else if ($urandom_range(0, 3) == 0)
					rsp_hold = stall_len();
				else if ($urandom_range(0, 199) == 0)
					rsp_calm = $urandom_range(30, 150);
			end
		end
	end

	always @(posedge clk) begin : check_words
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				report("unexpected word, status", '0, ADDR_W'(rsp.data.status));
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.data.status !== want.status)
					report("status", ADDR_W'(want.status), ADDR_W'(rsp.data.status));
				if (rsp.data.granted_address !== want.granted_address)
					report("granted_address", want.granted_address, rsp.data.granted_address);
				if (rsp.data.used_bytes !== want.used_bytes)
					report("used_bytes", ADDR_W'(want.used_bytes), ADDR_W'(rsp.data.used_bytes));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("arena_bump_and_slab_allocator_unit_test: errors");
			$finish;
		end
	end

	initial begin
		logic [1:0] pol;
		int unsigned cap;
		int unsigned count;
		logic [ADDR_W-1:0] base;
		cfg.valid = 1'b0;
		cfg.data = '0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bump: zero size, rounding, oversize, ignored ops, exact fill
		set_mode(POL_BUMP, ARENA, '0);
		queue_item(OP_ALLOC, 0, '0);
		queue_item(OP_ALLOC, 1, 32'hFFFF_FFFF);
		queue_item(OP_ALLOC, 131071, '0);
		queue_item(OP_FREE, 32, 32);
		queue_item(OP_SPARE, 0, '0);
		queue_item(OP_ALLOC, 65528, '0);
		queue_item(OP_ALLOC, 0, '0);
		queue_item(OP_ALLOC, 1, '0);
		queue_item(OP_RESET, 0, '0);
		settle();

		// slab: carve, pop, bad frees, wrapping base, list clear
		set_mode(POL_SLAB, ARENA, 32'hFFFF_FFE0);
		queue_item(OP_ALLOC, 0, '0);
		queue_item(OP_ALLOC, 32, '0);
		queue_item(OP_ALLOC, 33, '0);
		queue_item(OP_ALLOC, 4096, '0);
		queue_item(OP_ALLOC, 4097, '0);
		queue_item(OP_FREE, 32, 32'hFFFF_FFE0);
		queue_item(OP_FREE, 32, 32'hFFFF_FFE4);
		queue_item(OP_FREE, 32, 32'hFFFF_FFE0 + ARENA);
		queue_item(OP_FREE, 32, 32'hFFFF_FFC0);
		queue_item(OP_FREE, 4100, 32'hFFFF_FFE0);
		queue_item(OP_ALLOC, 32, '0);
		queue_item(OP_RESET, 0, '0);
		queue_item(OP_ALLOC, 1024, '0);
		queue_item(OP_ALLOC, 8, '0);
		settle();

		// persistent: capacity dropped below the bump pointer, reset ignored
		write_reg(REG_POLICY, ADDR_W'(POL_BUMP));
		queue_item(OP_RESET, 0, '0);
		queue_item(OP_ALLOC, 4000, '0);
		settle();
		write_reg(REG_CAPACITY, 1000);
		write_reg(REG_POLICY, ADDR_W'(POL_PERSIST));
		queue_item(OP_ALLOC, 0, '0);
		queue_item(OP_RESET, 0, '0);
		settle();
		set_mode(POL_SPARE, 0, 32'hFFFF_FFFF);
		queue_item(OP_ALLOC, 0, '0);
		queue_item(OP_RESET, 0, '0);
		queue_item(OP_FREE, 32, '0);
		settle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin pol = POL_SLAB;    cap = ARENA;                        base = $urandom(); end
				1: begin pol = POL_BUMP;    cap = $urandom_range(0, ARENA);     base = $urandom(); end
				2: begin pol = POL_SLAB;    cap = 131071;                       base = '0; end
				3: begin pol = POL_PERSIST; cap = ARENA;                        base = $urandom(); end
				4: begin pol = POL_SLAB;    cap = $urandom_range(4096, ARENA);  base = $urandom(); end
				5: begin pol = POL_SPARE;   cap = $urandom_range(0, ARENA);     base = 32'hFFFF_FFFF; end
				6: begin pol = POL_BUMP;    cap = ARENA;                        base = '0; end
				default: begin pol = POL_SLAB; cap = ARENA;                     base = $urandom(); end
			endcase
			if (pol == POL_PERSIST || pol == POL_SPARE || $urandom_range(0, 1) == 0) begin
				// rewind first so a persistent phase starts with room
				write_reg(REG_POLICY, ADDR_W'(POL_BUMP));
				queue_item(OP_RESET, 0, '0);
				settle();
			end
			set_mode(pol, cap, base);
			count = (pol == POL_SLAB) ? 300 : 190;
			for (int n = 0; n < count; n++)
				queue_random(pol);
			settle();
		end

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("arena_bump_and_slab_allocator_unit_test: clean");
		else
			$display("arena_bump_and_slab_allocator_unit_test: errors");
		$finish;
	end

endmodule
